/* design/wsp_pkg.sv */
// Shared types, codes and helpers of the wildcard star pattern matcher.
// No dependencies; every other design file imports this package.
package wsp_pkg;

	// field and register widths
	localparam int SYM_W        = 5;
	localparam int LETTER_W     = 5;
	localparam int LEN_W        = 5;
	localparam int CFG_W        = 60;
	localparam int REG_IDX_W    = 2;
	localparam int SYMS_PER_REG = CFG_W / SYM_W;
	localparam int PAT_SLOTS    = 2 * SYMS_PER_REG;

	// default pattern capacity
	localparam int MAX_PATTERN_DEF = 24;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_SYM_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SYM_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEN      = 2'd2;

	// pattern symbol codes
	localparam logic [SYM_W-1:0] SYM_NUM_LETTERS = 5'd26;
	localparam logic [SYM_W-1:0] SYM_DOT         = 5'd26;
	localparam logic [SYM_W-1:0] SYM_STAR        = 5'd27;

	// request codes
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_APPEND = 1'b1;

	typedef logic [SYM_W-1:0] sym_t;

	// decoded pattern: symbols, and length already saturated to capacity
	typedef struct packed {
		sym_t [PAT_SLOTS-1:0] syms;
		logic [LEN_W-1:0]     len;
	} pat_cfg_t;

	// true when a single pattern symbol consumes the given text letter
	function automatic logic sym_takes(sym_t sym, logic [LETTER_W-1:0] letter);
		return (sym == SYM_DOT) || ((sym < SYM_NUM_LETTERS) && (sym == letter));
	endfunction

endpackage

/* design/wsp_req_if.sv */
// Request channel: valid/ready handshake carrying one request item.
// Depends on wsp_pkg for the letter width.
interface wsp_req_if;
	import wsp_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [LETTER_W-1:0] text_letter;

	modport source (output valid, output req_type, output text_letter, input ready);
	modport sink   (input valid, input req_type, input text_letter, output ready);
endinterface

/* design/wsp_res_if.sv */
// Result channel: valid/ready handshake carrying one match result item.
// Depends on wsp_pkg only through the shared import convention.
interface wsp_res_if;
	import wsp_pkg::*;

	logic valid;
	logic ready;
	logic whole_match;
	logic still_alive;

	modport source (output valid, output whole_match, output still_alive, input ready);
	modport sink   (input valid, input whole_match, input still_alive, output ready);
endinterface

/* design/wsp_cfg_regs.sv */
// Pattern configuration registers and their decode into a symbol array.
// Depends on wsp_pkg for widths, register indexes and pat_cfg_t.
module wsp_cfg_regs #(
	parameter int MAX_PATTERN = wsp_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [wsp_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wsp_pkg::CFG_W-1:0]        wr_data,
	output wsp_pkg::pat_cfg_t                pat
);
	import wsp_pkg::*;

	logic [CFG_W-1:0] sym_low_q;
	logic [CFG_W-1:0] sym_high_q;
	logic [LEN_W-1:0] len_q;

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_low_q  <= '0;
			sym_high_q <= '0;
			len_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYM_LOW:  sym_low_q  <= wr_data;
				REG_SYM_HIGH: sym_high_q <= wr_data;
				REG_LEN:      len_q      <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack symbols, low register first
	for (genvar k = 0; k < SYMS_PER_REG; k++) begin : g_unpack
		assign pat.syms[k]                = sym_low_q[SYM_W*k +: SYM_W];
		assign pat.syms[k + SYMS_PER_REG] = sym_high_q[SYM_W*k +: SYM_W];
	end

	// clamp length to capacity
	assign pat.len = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;

endmodule

/* design/wsp_col_step.sv */
// One column step of the dot/star matching table: new prefix bits from the
// old column, the request and the pattern. Depends on wsp_pkg.
module wsp_col_step #(
	parameter int MAX_PATTERN = wsp_pkg::MAX_PATTERN_DEF
) (
	input  wsp_pkg::pat_cfg_t                pat,
	input  logic                             req_type,
	input  logic [wsp_pkg::LETTER_W-1:0]     text_letter,
	input  logic [MAX_PATTERN:0]             old_col,
	output logic [MAX_PATTERN:0]             new_col,
	output logic                             whole_match,
	output logic                             still_alive
);
	import wsp_pkg::*;

	localparam int IDX_W = $clog2(MAX_PATTERN + 1);

	logic             append;
	logic [IDX_W-1:0] len_i;

	assign append = (req_type == REQ_APPEND);
	assign len_i  = pat.len[IDX_W-1:0];

	// a start request opens with the empty prefix matched
	assign new_col[0] = (req_type == REQ_START);

	// prefix bit i: star skips back two prefixes or repeats its symbol,
	// other symbols consume the letter from prefix i-1
	for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_bit
		logic in_use;
		logic is_star;
		logic bit_val;

		assign in_use  = (len_i >= IDX_W'(i));
		assign is_star = (pat.syms[i-1] == SYM_STAR);

		if (i >= 2) begin : g_star_ok
			logic star_bit;
			assign star_bit = new_col[i-2] |
				(append & sym_takes(pat.syms[i-2], text_letter) & old_col[i]);
			assign bit_val = is_star ? star_bit :
				(append & sym_takes(pat.syms[i-1], text_letter) & old_col[i-1]);
		end else begin : g_lead
			// leading star has nothing to repeat
			assign bit_val = !is_star &
				append & sym_takes(pat.syms[i-1], text_letter) & old_col[i-1];
		end

		assign new_col[i] = in_use & bit_val;
	end

	assign whole_match = new_col[len_i];
	assign still_alive = |new_col;

endmodule

/* design/wildcard_star_pattern_matcher_unit.sv */
// Wildcard star pattern matcher, top level.
// An item goes from the input stage to the result register, which drives valid.
// Throughput: one item per cycle when not stalled; the column update of one item
// is a single combinational pass between the input stage and the result register.
// Reset (asynchronous, active low): empty pipeline, pattern cleared, column = bit 0.
module wildcard_star_pattern_matcher_unit #(
	parameter int MAX_PATTERN = wsp_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [wsp_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wsp_pkg::CFG_W-1:0]        wr_data,
	wsp_req_if.sink                          request,
	wsp_res_if.source                        result
);
	import wsp_pkg::*;

	pat_cfg_t            pat;
	logic                valid_s1;
	logic                req_type_s1;
	logic [LETTER_W-1:0] letter_s1;
	logic [MAX_PATTERN:0] column_q;
	logic [MAX_PATTERN:0] col_next;
	logic                whole_next;
	logic                alive_next;
	logic                res_valid_q;
	logic                whole_q;
	logic                alive_q;
	logic                advance;

	wsp_cfg_regs #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pat      (pat)
	);

	wsp_col_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
		.pat         (pat),
		.req_type    (req_type_s1),
		.text_letter (letter_s1),
		.old_col     (column_q),
		.new_col     (col_next),
		.whole_match (whole_next),
		.still_alive (alive_next)
	);

	// move the staged item into the result register when it is free
	assign advance       = valid_s1 && (!res_valid_q || result.ready);
	assign request.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.valid && request.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			req_type_s1 <= request.req_type;
			letter_s1   <= request.text_letter;
		end
	end

	// column state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			column_q    <= (MAX_PATTERN+1)'(1);
		end else if (advance) begin
			res_valid_q <= 1'b1;
			column_q    <= col_next;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			whole_q <= whole_next;
			alive_q <= alive_next;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.whole_match = whole_q;
	assign result.still_alive = alive_q;

	// a full input stage behind a stalled result holds off new items
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !result.ready) |-> !request.ready)
		else $error("request accepted while pipeline is stalled");

	// a start request leaves the empty prefix matched
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_type_s1 == REQ_START)) |=> column_q[0])
		else $error("start request did not set prefix bit 0");

	// an appended letter always clears the empty prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_type_s1 == REQ_APPEND)) |=> !column_q[0])
		else $error("letter left prefix bit 0 set");

	// a whole match is also a live prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.whole_match || result.still_alive))
		else $error("whole match reported without a live prefix");

endmodule
